[sv/csvt_pkg.sv]
// Package for the quoted CSV field tokenizer.
// Holds payload structs, the command passed from front to back, character
// constants and the back-end sequencer states. Depends on nothing.
package csvt_pkg;

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] BSLASH_CH = 8'h5C;
  localparam logic [7:0] SPACE_CH  = 8'h20;
  localparam logic [7:0] TAB_CH    = 8'h09;
  localparam logic [7:0] LF_CH     = 8'h0A;
  localparam logic [7:0] CR_CH     = 8'h0D;

  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
  localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic [7:0] line_delimiter;
    logic       last_in_line;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       field_end;
    logic       line_end;
    logic       trim_overflow;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic       push0_valid;
    logic [7:0] push0_byte;
    logic       push1_valid;
    logic [7:0] push1_byte;
    logic       field_end;
    logic       line_end;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PUSH0,
    BK_PUSH1,
    BK_FIELD,
    BK_LINE,
    BK_SEAL
  } bk_state_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == SPACE_CH) || (b == TAB_CH) || (b == LF_CH) || (b == CR_CH);
  endfunction

endpackage

[sv/quoted_csv_field_tokenizer.sv]
// A character's result passes through the command queue, the back end's command register,
// its staging register and its output register. The back end takes a step per content
// push or field/line end, one more per held whitespace byte flushed, and a closing seal
// step per character that reaches it, even when it yields no result. Characters with no
// command (an opening quote, a pending quote or escape) are accepted if the queue has room.
// Reset (rst, synchronous) clears quoting state, the command queue and the hold count.
module quoted_csv_field_tokenizer #(
  parameter int HOLD_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  csvt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output csvt_pkg::out_t out_data
);

  logic           fq_valid, fq_ready;
  csvt_pkg::cmd_t fq_data;
  logic           qb_valid, qb_ready;
  csvt_pkg::cmd_t qb_data;

  csvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  csvt_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/csvt_front.sv]
// Front end of the tokenizer: accepts characters and tracks quoting state.
// Each character that yields content pushes or field/line ends becomes a command.
// Depends on csvt_pkg.
module csvt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  csvt_pkg::in_t  in_data,
  output logic           q_valid,
  input  logic           q_ready,
  output csvt_pkg::cmd_t q_data
);

  logic quoted_mode, quoted_mode_next;
  logic at_start_of_field, at_start_of_field_next;
  logic quote_seen_pending, quote_seen_pending_next;
  logic escape_pending, escape_pending_next;
  logic accept;
  csvt_pkg::cmd_t cmd;

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    logic       last;
    logic       handled;
    c    = in_data.in_byte;
    d    = in_data.line_delimiter;
    last = in_data.last_in_line;
    handled = 1'b0;
    cmd = '0;
    quoted_mode_next        = quoted_mode;
    at_start_of_field_next  = at_start_of_field;
    quote_seen_pending_next = quote_seen_pending;
    escape_pending_next     = escape_pending;

    if (escape_pending) begin
      escape_pending_next = 1'b0;
      cmd.push0_valid = 1'b1;
      cmd.push0_byte  = c;
      at_start_of_field_next = 1'b0;
      handled = 1'b1;
    end else if (quote_seen_pending) begin
      quote_seen_pending_next = 1'b0;
      if (c == csvt_pkg::QUOTE_CH) begin
        cmd.push0_valid = 1'b1;
        cmd.push0_byte  = csvt_pkg::QUOTE_CH;
        handled = 1'b1;
      end else if (c == d) begin
        quoted_mode_next = 1'b0;
      end else begin
        cmd.push0_valid = 1'b1;
        cmd.push0_byte  = csvt_pkg::QUOTE_CH;
      end
    end

    if (!handled) begin
      if (c == csvt_pkg::QUOTE_CH) begin
        if (quoted_mode_next) begin
          if (last) begin
            quoted_mode_next = 1'b0;
          end else begin
            quote_seen_pending_next = 1'b1;
          end
        end else if (at_start_of_field_next) begin
          quoted_mode_next = 1'b1;
        end else if (!cmd.push0_valid) begin
          cmd.push0_valid = 1'b1;
          cmd.push0_byte  = csvt_pkg::QUOTE_CH;
        end else begin
          cmd.push1_valid = 1'b1;
          cmd.push1_byte  = csvt_pkg::QUOTE_CH;
        end
      end else if (quoted_mode_next && (c == csvt_pkg::BSLASH_CH) && !last) begin
        escape_pending_next = 1'b1;
      end else if ((c == d) && !quoted_mode_next) begin
        cmd.field_end = 1'b1;
        at_start_of_field_next = 1'b1;
      end else begin
        if (!cmd.push0_valid) begin
          cmd.push0_valid = 1'b1;
          cmd.push0_byte  = c;
        end else begin
          cmd.push1_valid = 1'b1;
          cmd.push1_byte  = c;
        end
        at_start_of_field_next = 1'b0;
      end
    end

    if (last) begin
      cmd.line_end = 1'b1;
      at_start_of_field_next  = 1'b1;
      quoted_mode_next        = 1'b0;
      quote_seen_pending_next = 1'b0;
      escape_pending_next     = 1'b0;
    end
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_valid  = in_valid && (cmd.push0_valid || cmd.field_end || cmd.line_end);
  assign q_data   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      quoted_mode        <= 1'b0;
      at_start_of_field  <= 1'b1;
      quote_seen_pending <= 1'b0;
      escape_pending     <= 1'b0;
    end else if (accept) begin
      quoted_mode        <= quoted_mode_next;
      at_start_of_field  <= at_start_of_field_next;
      quote_seen_pending <= quote_seen_pending_next;
      escape_pending     <= escape_pending_next;
    end
  end

endmodule

[sv/csvt_queue.sv]
// Short command queue between the front and back ends of the tokenizer.
// Register-based ring buffer with a fill count. Depends on csvt_pkg.
module csvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  csvt_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csvt_pkg::cmd_t pop_data
);

  localparam int DEPTH = csvt_pkg::CMD_QUEUE_DEPTH;
  localparam int PTR_W = csvt_pkg::CMD_PTR_W;
  localparam int CNT_W = csvt_pkg::CMD_CNT_W;

  csvt_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic push;
  logic pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH)) else $error("queue fill exceeds depth");
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1)) else $error("queue fill did not grow");
  a_fill_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (fill == $past(fill) - 1'b1)) else $error("queue fill did not shrink");

endmodule

[sv/csvt_back.sv]
// Back end of the tokenizer: carries out commands against the trailing
// whitespace hold and produces result transactions. Depends on csvt_pkg.
module csvt_back #(
  parameter int HOLD_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  csvt_pkg::cmd_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output csvt_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  csvt_pkg::bk_state_t state, state_next;
  csvt_pkg::cmd_t      cmd;
  logic [7:0]          hold [HOLD_DEPTH];
  logic [CNT_W-1:0]    count, count_next;
  logic                content_started, content_started_next;
  logic                st_full;
  csvt_pkg::out_t      st_data;
  logic                o_full;
  csvt_pkg::out_t      o_data;
  csvt_pkg::out_t      moved;

  logic [7:0]          cur_byte;
  logic                o_free, adv_ok;
  logic                gen, op_done, step, seal, load, move;
  logic                hold_shift, hold_wr;
  logic [IDX_W-1:0]    hold_idx;
  csvt_pkg::out_t      raw;

  function automatic csvt_pkg::bk_state_t first_phase(input csvt_pkg::cmd_t c);
    if (c.push0_valid) return csvt_pkg::BK_PUSH0;
    if (c.field_end)   return csvt_pkg::BK_FIELD;
    if (c.line_end)    return csvt_pkg::BK_LINE;
    return csvt_pkg::BK_SEAL;
  endfunction

  assign cur_byte = (state == csvt_pkg::BK_PUSH1) ? cmd.push1_byte : cmd.push0_byte;
  assign o_free   = !o_full || out_ready;
  assign adv_ok   = !st_full || o_free;
  assign q_ready  = (state == csvt_pkg::BK_IDLE) || ((state == csvt_pkg::BK_SEAL) && adv_ok);
  assign load     = q_valid && q_ready;
  assign step     = gen && adv_ok;
  assign seal     = (state == csvt_pkg::BK_SEAL) && adv_ok;
  assign move     = st_full && (step || seal);

  always_comb begin
    raw = '0;
    gen = 1'b0;
    op_done = 1'b0;
    hold_shift = 1'b0;
    hold_wr = 1'b0;
    hold_idx = count[IDX_W-1:0];
    count_next = count;
    content_started_next = content_started;
    unique case (state)
      csvt_pkg::BK_PUSH0, csvt_pkg::BK_PUSH1: begin
        if (csvt_pkg::is_space(cur_byte)) begin
          if (!content_started) begin
            op_done = 1'b1;
          end else if (count == CNT_W'(HOLD_DEPTH)) begin
            gen = 1'b1;
            raw.out_byte = hold[0];
            raw.has_byte = 1'b1;
            raw.trim_overflow = 1'b1;
            if (adv_ok) begin
              op_done = 1'b1;
              hold_shift = 1'b1;
              hold_wr = 1'b1;
              hold_idx = IDX_W'(HOLD_DEPTH - 1);
            end
          end else begin
            op_done = 1'b1;
            hold_wr = 1'b1;
            count_next = count + 1'b1;
          end
        end else if (count != '0) begin
          gen = 1'b1;
          raw.out_byte = hold[0];
          raw.has_byte = 1'b1;
          if (adv_ok) begin
            hold_shift = 1'b1;
            count_next = count - 1'b1;
          end
        end else begin
          gen = 1'b1;
          raw.out_byte = cur_byte;
          raw.has_byte = 1'b1;
          if (adv_ok) begin
            op_done = 1'b1;
            content_started_next = 1'b1;
          end
        end
      end
      csvt_pkg::BK_FIELD, csvt_pkg::BK_LINE: begin
        gen = 1'b1;
        raw.field_end = 1'b1;
        raw.line_end = (state == csvt_pkg::BK_LINE);
        if (adv_ok) begin
          op_done = 1'b1;
          count_next = '0;
          content_started_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      csvt_pkg::BK_IDLE: begin
        if (load) state_next = first_phase(q_data);
      end
      csvt_pkg::BK_PUSH0: begin
        if (op_done) begin
          if (cmd.push1_valid)    state_next = csvt_pkg::BK_PUSH1;
          else if (cmd.field_end) state_next = csvt_pkg::BK_FIELD;
          else if (cmd.line_end)  state_next = csvt_pkg::BK_LINE;
          else                    state_next = csvt_pkg::BK_SEAL;
        end
      end
      csvt_pkg::BK_PUSH1: begin
        if (op_done) begin
          if (cmd.field_end)     state_next = csvt_pkg::BK_FIELD;
          else if (cmd.line_end) state_next = csvt_pkg::BK_LINE;
          else                   state_next = csvt_pkg::BK_SEAL;
        end
      end
      csvt_pkg::BK_FIELD: begin
        if (op_done) state_next = cmd.line_end ? csvt_pkg::BK_LINE : csvt_pkg::BK_SEAL;
      end
      csvt_pkg::BK_LINE: begin
        if (op_done) state_next = csvt_pkg::BK_SEAL;
      end
      csvt_pkg::BK_SEAL: begin
        if (adv_ok) state_next = load ? first_phase(q_data) : csvt_pkg::BK_IDLE;
      end
      default: state_next = csvt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    moved = st_data;
    moved.last_of_run = seal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= csvt_pkg::BK_IDLE;
      count           <= '0;
      content_started <= 1'b0;
      st_full         <= 1'b0;
      o_full          <= 1'b0;
    end else begin
      state           <= state_next;
      count           <= count_next;
      content_started <= content_started_next;
      if (step) begin
        st_full <= 1'b1;
      end else if (seal) begin
        st_full <= 1'b0;
      end
      if (move) begin
        o_full <= 1'b1;
      end else if (out_ready) begin
        o_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= q_data;
    end
    if (step) begin
      st_data <= raw;
    end
    if (move) begin
      o_data <= moved;
    end
    if (hold_shift) begin
      for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
        hold[i] <= hold[i+1];
      end
    end
    if (hold_wr) begin
      hold[hold_idx] <= cur_byte;
    end
  end

  assign out_valid = o_full;
  assign out_data  = o_data;

  a_byte_or_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.has_byte && out_data.field_end))
    else $error("result carries both a byte and a field end");
  a_ovf_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.trim_overflow) |-> out_data.has_byte)
    else $error("overflow flag without a byte");
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.line_end) |-> (out_data.field_end && out_data.last_of_run))
    else $error("line end is not the closing field end of its run");
  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HOLD_DEPTH)) else $error("whitespace hold count out of range");

endmodule
